@@ design/adsr_pkg.sv @@
// Package: shared types and constants of the ADSR envelope generator.
`default_nettype none
package adsr_pkg;

  localparam int unsigned AmpW    = 17;  // Q1.16 amplitude
  localparam int unsigned SampleW = 16;
  localparam int unsigned HoldW   = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 24;

  typedef logic        [AmpW-1:0]    amp_t;
  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic        [HoldW-1:0]   hold_t;
  typedef logic        [CfgIdxW-1:0] cfg_idx_t;
  typedef logic        [CfgW-1:0]    cfg_data_t;

  localparam amp_t AmpOne = 17'h10000;

  // Register indexes of the configuration port
  localparam cfg_idx_t RegAttackStep    = 3'd0;
  localparam cfg_idx_t RegDecayFactor   = 3'd1;
  localparam cfg_idx_t RegSustainLevel  = 3'd2;
  localparam cfg_idx_t RegReleaseFactor = 3'd3;
  localparam cfg_idx_t RegHoldSamples   = 3'd4;

endpackage
`default_nettype wire

@@ design/adsr_if.sv @@
// Interfaces: sample input channel and shaped sample output channel.
`default_nettype none
interface adsr_in_if;
  import adsr_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_in;
  logic    gate;
  modport source (output valid, output sample_in, output gate, input ready);
  modport sink   (input valid, input sample_in, input gate, output ready);
endinterface

interface adsr_out_if;
  import adsr_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface
`default_nettype wire

@@ design/adsr_envelope_generator_unit.sv @@
// ADSR envelope generator: shapes each audio sample by an attack/decay/hold/release envelope.
//
// One item (sample plus gate) is taken at a time: the accept cycle
// runs the gate check and the attack add, then one shared 18x18 multiplier
// is used in the states DECAY, REL and SCALE, in turn for the decay product, the
// release product and the output scaling (sample * amplitude >> 16). The
// input is ready only while the sequencer is idle. The result sits in an
// output register, so a waiting result does not block the next item; a
// result is only held back at the scaling step if the previous one has not
// been taken yet. Configuration writes (index 0..4: attack step, decay
// factor, sustain level, release factor, hold samples) take effect at once
// and should be made only while no item is in flight; other indexes are
// ignored.
`default_nettype none
module adsr_envelope_generator_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire adsr_pkg::cfg_idx_t cfg_idx_i,
  input  wire adsr_pkg::cfg_data_t cfg_data_i,
  adsr_in_if.sink                 sample_i,
  adsr_out_if.source              result_o
);
  import adsr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECAY,
    ST_REL,
    ST_SCALE
  } state_e;

  // configuration registers
  logic [16:0] attack_step_q;
  logic [15:0] decay_factor_q;
  amp_t        sustain_level_q;
  logic [15:0] release_factor_q;
  hold_t       hold_samples_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_step_q    <= 17'd655;
      decay_factor_q   <= 16'd65000;
      sustain_level_q  <= 17'd32768;
      release_factor_q <= 16'd65000;
      hold_samples_q   <= 24'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegAttackStep:    attack_step_q    <= cfg_data_i[16:0];
        RegDecayFactor:   decay_factor_q   <= cfg_data_i[15:0];
        RegSustainLevel:  sustain_level_q  <= cfg_data_i[16:0];
        RegReleaseFactor: release_factor_q <= cfg_data_i[15:0];
        RegHoldSamples:   hold_samples_q   <= cfg_data_i[HoldW-1:0];
        default: ;
      endcase
    end
  end

  // envelope state
  state_e  state_q;
  amp_t    amp_q;
  logic    att_q, dec_q, hold_q, rel_q;
  hold_t   cnt_q;
  sample_t last_q;      // doubles as the output register
  logic    out_valid_q;
  logic    wr_q;        // some phase writes the output this item
  sample_t smp_q;
  logic    gate_q;

  assign sample_i.ready    = (state_q == ST_IDLE);
  assign result_o.valid    = out_valid_q;
  assign result_o.sample_out = last_q;

  wire accept   = sample_i.valid && sample_i.ready;
  wire out_free = !out_valid_q || result_o.ready;

  // shared multiplier: amplitude * factor, or sample * amplitude
  logic signed [17:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [35:0] prod;
  amp_t               mul_amp;

  always_comb begin
    unique case (state_q)
      ST_DECAY: begin
        mul_a = $signed({1'b0, amp_q});
        mul_b = $signed({2'b00, decay_factor_q});
      end
      ST_REL: begin
        mul_a = $signed({1'b0, amp_q});
        mul_b = $signed({2'b00, release_factor_q});
      end
      default: begin
        mul_a = $signed({{2{smp_q[SampleW-1]}}, smp_q});
        mul_b = $signed({1'b0, amp_q});
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign mul_amp = prod[32:16];

  // accept cycle: gate check and attack step
  logic        start;
  logic [17:0] att_sum;
  logic        att1, dec1, rel1, wr1;
  hold_t       cnt1;
  amp_t        amp1;

  always_comb begin
    start   = sample_i.gate && !att_q && !hold_q && !dec_q;
    att1    = att_q || start;
    dec1    = start ? 1'b0 : dec_q;
    rel1    = start ? 1'b0 : rel_q;
    cnt1    = start ? '0 : cnt_q;
    att_sum = {1'b0, amp_q} + {1'b0, attack_step_q};
    amp1    = amp_q;
    wr1     = att1;
    if (att1) begin
      rel1 = 1'b0;
      if (att_sum >= {1'b0, AmpOne}) begin
        amp1 = AmpOne;
        att1 = 1'b0;
        dec1 = 1'b1;
      end else begin
        amp1 = att_sum[AmpW-1:0];
      end
    end
  end

  // release cycle: hold count, gate check, release multiply
  logic  hold_run, expired, do_rel, hold2, rel2, wr2;
  hold_t cnt2;
  amp_t  amp2;

  always_comb begin
    hold_run = (cnt_q < hold_samples_q) && hold_q;
    cnt2     = hold_run ? cnt_q + 1'b1 : cnt_q;
    expired  = (cnt2 >= hold_samples_q);
    hold2    = (expired && !gate_q) ? 1'b0 : hold_q;
    rel2     = (expired && !gate_q) ? 1'b1 : rel_q;
    do_rel   = rel2 && (amp_q != '0);
    amp2     = do_rel ? mul_amp : amp_q;
    wr2      = wr_q || hold_run || (expired && gate_q) || do_rel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      amp_q       <= '0;
      att_q       <= 1'b0;
      dec_q       <= 1'b0;
      hold_q      <= 1'b0;
      rel_q       <= 1'b0;
      cnt_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
      wr_q        <= 1'b0;
      smp_q       <= '0;
      gate_q      <= 1'b0;
    end else begin
      // output register fills at the scaling step, empties when taken
      if (state_q == ST_SCALE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            smp_q   <= sample_i.sample_in;
            gate_q  <= sample_i.gate;
            att_q   <= att1;
            dec_q   <= dec1;
            rel_q   <= rel1;
            cnt_q   <= cnt1;
            amp_q   <= amp1;
            wr_q    <= wr1;
            state_q <= ST_DECAY;
          end
        end
        ST_DECAY: begin
          if (dec_q) begin
            amp_q <= mul_amp;
            wr_q  <= 1'b1;
            if (mul_amp <= sustain_level_q) begin
              dec_q  <= 1'b0;
              hold_q <= 1'b1;
            end
          end
          state_q <= ST_REL;
        end
        ST_REL: begin
          cnt_q   <= cnt2;
          hold_q  <= hold2;
          rel_q   <= rel2;
          amp_q   <= amp2;
          wr_q    <= wr2;
          state_q <= ST_SCALE;
        end
        ST_SCALE: begin
          // wait until the previous result has left the output register
          if (out_free) begin
            if (wr_q) last_q <= prod[31:16];
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
